### hw/rtl/assert_macros.svh
// Assertion macros shared by the run-length decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clk_i edge while rst_ni is high.
`define RLSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks a property on every rising clk_i edge, reset included.
`define RLSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/rlsd_pkg.sv
// Types and constants shared by the run-length stream decoder modules.
package rlsd_pkg;

  // One byte of the compressed stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0] data_first;
    logic [7:0] data_second;
    logic [1:0] byte_count;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  // Work handed from the front to the back: emit len copies of value,
  // two per result, and put status on the final result.
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] len;
    logic [1:0] status;
  } cmd_t;

  localparam logic [1:0] ST_DATA      = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  localparam logic [7:0] CTRL_REPEAT   = 8'h80;
  localparam logic [7:0] CTRL_LEN_MASK = 8'h7F;

endpackage

### hw/rtl/rlsd_front.sv
// Front end: parses header and control bytes and issues emit commands.
`include "assert_macros.svh"

module rlsd_front import rlsd_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_CONTROL = 3'd1,
    PH_LITERAL = 3'd2,
    PH_REPEAT  = 3'd3,
    PH_DONE    = 3'd4
  } phase_e;

  localparam logic [4:0] HDR_END = 5'(HEADER_BYTES);

  phase_e      phase_q, phase_d;
  logic [3:0]  hidx_q, hidx_d, hidx_inc;
  logic [31:0] chunks_q, chunks_d, chunks_dec;
  logic [7:0]  run_q, run_d, run_dec;
  logic        accept, fin, has_data;
  logic [7:0]  cmd_len;
  logic [1:0]  status;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign hidx_inc   = hidx_q + 4'd1;
  assign chunks_dec = chunks_q - 32'd1;
  assign run_dec    = run_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    hidx_d   = hidx_q;
    chunks_d = chunks_q;
    run_d    = run_q;
    fin      = 1'b0;
    has_data = 1'b0;
    cmd_len  = '0;
    case (phase_q)
      PH_HEADER: begin
        // Bytes four to seven carry the chunk count, least significant first.
        if (hidx_q[3:2] == 2'b01) begin
          if (hidx_q[1:0] == 2'd0) begin
            chunks_d = '0;
          end
          chunks_d[{hidx_q[1:0], 3'b000} +: 8] = in_item_i.in_byte;
        end
        hidx_d = hidx_inc;
        if (hidx_inc == '0 || {1'b0, hidx_inc} >= HDR_END) begin
          hidx_d = '0;
          if (chunks_d == '0) begin
            phase_d = PH_DONE;
            fin     = 1'b1;
          end else begin
            phase_d = PH_CONTROL;
          end
        end
      end
      PH_CONTROL: begin
        run_d   = (in_item_i.in_byte & CTRL_LEN_MASK) + 8'd1;
        phase_d = ((in_item_i.in_byte & CTRL_REPEAT) != '0) ? PH_REPEAT : PH_LITERAL;
      end
      PH_LITERAL: begin
        has_data = 1'b1;
        cmd_len  = 8'd1;
        run_d    = run_dec;
        if (run_dec == '0) begin
          chunks_d = chunks_dec;
          fin      = (chunks_dec == '0);
          phase_d  = fin ? PH_DONE : PH_CONTROL;
        end
      end
      PH_REPEAT: begin
        has_data = 1'b1;
        cmd_len  = run_q;
        run_d    = '0;
        chunks_d = chunks_dec;
        fin      = (chunks_dec == '0);
        phase_d  = fin ? PH_DONE : PH_CONTROL;
      end
      default: begin
      end
    endcase

    if (fin) begin
      status = ST_DONE;
    end else if (in_item_i.end_of_input && phase_d != PH_DONE) begin
      status = ST_EARLY_END;
    end else begin
      status = ST_DATA;
    end

    // The final byte of a stream always re-arms the parser for a new header.
    if (in_item_i.end_of_input) begin
      phase_d  = PH_HEADER;
      hidx_d   = '0;
      chunks_d = '0;
      run_d    = '0;
    end
  end

  assign q_push_o       = accept && (has_data || status != ST_DATA);
  assign q_cmd_o.value  = has_data ? in_item_i.in_byte : 8'd0;
  assign q_cmd_o.len    = cmd_len;
  assign q_cmd_o.status = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      hidx_q   <= '0;
      chunks_q <= '0;
      run_q    <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      hidx_q   <= hidx_d;
      chunks_q <= chunks_d;
      run_q    <= run_d;
    end
  end

  `RLSD_ASSERT(a_eoi_rearms,
    accept && in_item_i.end_of_input |=> phase_q == PH_HEADER && hidx_q == '0,
    "parser not re-armed after end of input")

endmodule

### hw/rtl/rlsd_queue.sv
// Small command queue between the front and the back.
`include "assert_macros.svh"

module rlsd_queue import rlsd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `RLSD_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
  `RLSD_ASSERT(a_no_underflow, pop_i |-> valid_o, "pop from an empty queue")

endmodule

### hw/rtl/rlsd_back.sv
// Back end: expands queued commands into results in an output register.
`include "assert_macros.svh"

module rlsd_back import rlsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic [7:0] sent_q, rem;
  logic       load, last, two;

  assign load = q_valid_i && (!out_valid_q || !out_stall_i);
  assign rem  = q_cmd_i.len - sent_q;
  assign last = (rem <= 8'd2);
  assign two  = (rem >= 8'd2);

  always_comb begin
    out_d.data_first  = q_cmd_i.value;
    out_d.data_second = two ? q_cmd_i.value : 8'd0;
    if (rem == '0) begin
      out_d.byte_count = CNT_NONE;
    end else begin
      out_d.byte_count = two ? CNT_TWO : CNT_ONE;
    end
    out_d.status      = last ? q_cmd_i.status : ST_DATA;
    out_d.last_of_run = last;
  end

  assign q_pop_o     = load && last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= '0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      sent_q      <= last ? 8'd0 : sent_q + 8'd2;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  `RLSD_ASSERT(a_status_on_last,
    out_valid_q && out_q.status != ST_DATA |-> out_q.last_of_run,
    "status carried by a result that is not the last of its byte")
  `RLSD_ASSERT(a_partial_cmd_held,
    sent_q != '0 |-> q_valid_i && sent_q < q_cmd_i.len,
    "partly expanded command left the queue head")

endmodule

### hw/rtl/run_length_stream_decoder_top.sv
// Top level of the run-length stream decoder.
//
// The input channel takes one byte of a compressed stream per transfer, with
// end_of_input marking the final byte. The stream opens with a HEADER_BYTES
// header whose bytes four to seven give the chunk count; chunks follow, each a
// control byte and then either literal bytes or one byte to repeat.
// The output channel gives results of up to two decoded bytes. The last
// result caused by an input byte has last_of_run set and carries the status
// (all chunks decoded, or input ended early); a byte that yields only a
// status gets one result with byte_count zero. Header and control bytes
// give no result otherwise.
// The first result of a byte passes through the command queue and then the
// output register. Throughput is one byte per cycle for literal data while
// in_stall_o is low. A repeat byte with run length n+1 holds the output side
// for one result per two bytes of the run, one result per cycle from the
// expander while out_stall_i is low; the input keeps taking bytes until the
// QUEUE_DEPTH-entry parser-to-expander queue is full, then raises in_stall_o.
// When the receiver stalls, the output register holds its result and the
// queue fills behind it. Reset clears the parser to expect a header and
// empties the queue and the output register.
module run_length_stream_decoder_top import rlsd_pkg::*; #(
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned QUEUE_DEPTH  = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // Commands from the parser to the expander.
  logic push, full, pop, q_valid;
  cmd_t push_cmd, head_cmd;

  // The parser updates its state on every input transfer and pushes at most
  // one command per byte.
  rlsd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (full),
    .q_push_o  (push),
    .q_cmd_o   (push_cmd)
  );

  // The queue lets the parser run ahead while a long repeat drains.
  rlsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (head_cmd)
  );

  // The expander turns the queue head into results, two bytes at a time,
  // and pops it with the final result.
  rlsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (head_cmd),
    .q_pop_o    (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
